[src/assert_macros.svh]
// Assertion macros used by the checker file of the line filter.
// Depends on nothing; each macro takes a label, clock, active-low reset and terms.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[src/lpf_pkg.sv]
// Shared types and constants of the line pattern filter.
// No dependencies; imported by every module of the block.
package lpf_pkg;

    localparam int MAX_LINE_DEF    = 1024;
    localparam int PATTERN_MAX_DEF = 32;

    localparam int CH_W        = 8;
    localparam int COUNT_W     = 32;
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_INDEX_W = 3;
    localparam int PLEN_W      = 6;

    localparam logic [CH_W-1:0]    NEWLINE_CHAR = 8'h0A;
    localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_0    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LEN  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_INVERT       = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHOW_NUMBERS = 3'd6;

    typedef enum logic {
        KIND_CHAR = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        END_NEWLINE = 2'd0,
        END_LIMIT   = 2'd1,
        END_INPUT   = 2'd2
    } line_end_t;

    // Per-cycle control from the line tracker to the match unit
    typedef struct packed {
        logic take;    // buffered beat consumed this cycle
        logic feed;    // a character enters the shift-and vector
        logic finish;  // the current line closes this cycle
    } lpf_ctl_t;

endpackage

[src/lpf_match.sv]
// Shift-and substring matcher: match vector and per-line found flag.
// Depends on lpf_pkg.
module lpf_match #(
    parameter int PATTERN_MAX = lpf_pkg::PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lpf_pkg::lpf_ctl_t                  ctl,
    input  logic [lpf_pkg::CH_W-1:0]           ch,
    input  logic [PATTERN_MAX-1:0][lpf_pkg::CH_W-1:0] pattern_bytes,
    input  logic [LEN_W-1:0]                   eff_len,
    output logic                               matched
);
    import lpf_pkg::*;

    logic [PATTERN_MAX-1:0] vec_reg, vec_next;
    logic                   found_reg, found_next;
    logic [PATTERN_MAX-1:0] char_mask;
    logic [PATTERN_MAX-1:0] last_sel;
    logic [PATTERN_MAX-1:0] vec_new;
    logic                   hit;
    logic                   len_zero;

    assign len_zero = (eff_len == '0);

    always_comb begin
        for (int i = 0; i < PATTERN_MAX; i++) begin
            char_mask[i] = (LEN_W'(i) < eff_len) && (pattern_bytes[i] == ch);
            last_sel[i]  = (LEN_W'(i + 1) == eff_len);
        end
    end

    assign vec_new = ((vec_reg << 1) | PATTERN_MAX'(1)) & char_mask;
    assign hit     = |(vec_new & last_sel);

    assign matched = len_zero || found_reg || (ctl.feed && hit);

    always_comb begin
        vec_next   = vec_reg;
        found_next = found_reg;
        if (ctl.finish) begin
            vec_next   = '0;
            found_next = 1'b0;
        end else if (ctl.feed && !len_zero) begin
            vec_next   = vec_new;
            found_next = found_reg | hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            vec_reg   <= vec_next;
            found_reg <= found_next;
        end
    end

endmodule

[src/lpf_line.sv]
// Line tracker: character count, end-of-input flag, saturating counts
// and the result register. Depends on lpf_pkg.
module lpf_line #(
    parameter int MAX_LINE = lpf_pkg::MAX_LINE_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_valid,
    input  logic                           item_kind,
    input  logic [lpf_pkg::CH_W-1:0]       item_ch,
    input  logic                           invert,
    input  logic                           show_numbers,
    input  logic                           matched,
    output lpf_pkg::lpf_ctl_t              ctl,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_selected,
    output logic                           m_matched,
    output logic [lpf_pkg::COUNT_W-1:0]    m_line_number,
    output logic [lpf_pkg::COUNT_W-1:0]    m_selected_total,
    output logic [1:0]                     m_line_end
);
    import lpf_pkg::*;

    localparam int CNT_W = $clog2(MAX_LINE);

    logic [CNT_W-1:0]   chars_reg, chars_next;
    logic               fin_reg, fin_next;
    logic [COUNT_W-1:0] line_cnt_reg, line_cnt_next;
    logic [COUNT_W-1:0] sel_cnt_reg, sel_cnt_next;

    logic               out_vld_reg, out_vld_next;
    logic               out_sel_reg;
    logic               out_match_reg;
    logic [COUNT_W-1:0] out_num_reg;
    logic [COUNT_W-1:0] out_total_reg;
    line_end_t          out_end_reg;

    logic      is_char, is_nl, at_limit, line_done, out_free, sel;
    line_end_t end_code;

    assign is_char  = (item_kind == KIND_CHAR);
    assign is_nl    = (item_ch == NEWLINE_CHAR);
    assign at_limit = (chars_reg == CNT_W'(MAX_LINE - 2));

    assign line_done = !fin_reg &&
                       ((is_char && (is_nl || at_limit)) || (!is_char && chars_reg != '0));

    always_comb begin
        priority if (!is_char) begin
            end_code = END_INPUT;
        end else if (is_nl) begin
            end_code = END_NEWLINE;
        end else begin
            end_code = END_LIMIT;
        end
    end

    // A beat that closes a line needs the result register; others never stall
    assign out_free   = !out_vld_reg || m_ready;
    assign ctl.take   = item_valid && (!line_done || out_free);
    assign ctl.feed   = ctl.take && is_char && !fin_reg;
    assign ctl.finish = ctl.take && line_done;

    assign sel = matched ^ invert;

    always_comb begin
        chars_next    = chars_reg;
        fin_next      = fin_reg;
        line_cnt_next = line_cnt_reg;
        sel_cnt_next  = sel_cnt_reg;
        out_vld_next  = out_vld_reg && !m_ready;
        if (ctl.take && !is_char) begin
            fin_next = 1'b1;
        end
        if (ctl.finish) begin
            chars_next   = '0;
            out_vld_next = 1'b1;
            if (line_cnt_reg != COUNT_MAX) begin
                line_cnt_next = line_cnt_reg + COUNT_W'(1);
            end
            if (sel && sel_cnt_reg != COUNT_MAX) begin
                sel_cnt_next = sel_cnt_reg + COUNT_W'(1);
            end
        end else if (ctl.feed) begin
            chars_next = chars_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chars_reg    <= '0;
            fin_reg      <= 1'b0;
            line_cnt_reg <= '0;
            sel_cnt_reg  <= '0;
            out_vld_reg  <= 1'b0;
        end else begin
            chars_reg    <= chars_next;
            fin_reg      <= fin_next;
            line_cnt_reg <= line_cnt_next;
            sel_cnt_reg  <= sel_cnt_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Result payload: load on line close, hold otherwise
    always_ff @(posedge aclk) begin
        if (ctl.finish) begin
            out_sel_reg   <= sel;
            out_match_reg <= matched;
            out_num_reg   <= show_numbers ? line_cnt_next : '0;
            out_total_reg <= sel_cnt_next;
            out_end_reg   <= end_code;
        end
    end

    assign m_valid          = out_vld_reg;
    assign m_selected       = out_sel_reg;
    assign m_matched        = out_match_reg;
    assign m_line_number    = out_num_reg;
    assign m_selected_total = out_total_reg;
    assign m_line_end       = out_end_reg;

endmodule

[src/line_pattern_filter_unit.sv]
// Top level of the line pattern filter: configuration registers, input
// buffer, shift-and matcher and line tracker. Depends on lpf_pkg, lpf_match, lpf_line.
//
// Splits a byte stream into lines and reports, per line, whether a
// configured pattern of up to PATTERN_MAX bytes occurs in it, the line's
// selection (match xor invert), its 1-based number if enabled, and the
// running count of selected lines, both saturating. The block takes one
// beat per cycle. The shift-and vector update is a loop through a single
// register, which sets that rate. The input buffer register and the result
// register, which holds each closed line's result, decouple the two sides,
// so input keeps flowing while a result waits, stalling only when a second
// line closes before the first result is taken. After an end-of-input beat
// all further beats are consumed and ignored until reset. Configuration must
// be written only while the block is idle; the block does not enforce it.
module line_pattern_filter_unit #(
    parameter int MAX_LINE    = lpf_pkg::MAX_LINE_DEF,
    parameter int PATTERN_MAX = lpf_pkg::PATTERN_MAX_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lpf_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lpf_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_kind,
    input  logic [lpf_pkg::CH_W-1:0]          s_ch,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_selected,
    output logic                              m_matched,
    output logic [lpf_pkg::COUNT_W-1:0]       m_line_number,
    output logic [lpf_pkg::COUNT_W-1:0]       m_selected_total,
    output logic [1:0]                        m_line_end
);
    import lpf_pkg::*;

    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int BYTES_PER_W = CFG_DATA_W / CH_W;

    logic [PATTERN_MAX-1:0][CH_W-1:0] pat_reg;
    logic [PLEN_W-1:0]                plen_reg;
    logic                             invert_reg;
    logic                             show_reg;
    logic [LEN_W-1:0]                 eff_len;

    logic            in_vld_reg;
    logic            in_kind_reg;
    logic [CH_W-1:0] in_ch_reg;

    lpf_ctl_t ctl;
    logic     matched;

    // Pattern bytes: word w carries bytes BYTES_PER_W*w and up, byte 0 low
    for (genvar b = 0; b < PATTERN_MAX; b++) begin : g_pat
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pat_reg[b] <= '0;
            end else if (cfg_wr_en &&
                         cfg_index == CFG_PATTERN_0 + CFG_INDEX_W'(b / BYTES_PER_W)) begin
                pat_reg[b] <= cfg_wdata[(b % BYTES_PER_W) * CH_W +: CH_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_reg   <= '0;
            invert_reg <= 1'b0;
            show_reg   <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PATTERN_LEN:  plen_reg   <= cfg_wdata[PLEN_W-1:0];
                CFG_INVERT:       invert_reg <= cfg_wdata[0];
                CFG_SHOW_NUMBERS: show_reg   <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Clamp an overlong length to the pattern capacity
    assign eff_len = (plen_reg > PLEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                      : plen_reg[LEN_W-1:0];

    // Input buffer: refill on accept, drain when the tracker takes the beat
    assign s_ready = !in_vld_reg || ctl.take;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (ctl.take) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_ch_reg   <= s_ch;
        end
    end

    lpf_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_match (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (ctl),
        .ch            (in_ch_reg),
        .pattern_bytes (pat_reg),
        .eff_len       (eff_len),
        .matched       (matched)
    );

    lpf_line #(
        .MAX_LINE (MAX_LINE)
    ) u_line (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .item_valid       (in_vld_reg),
        .item_kind        (in_kind_reg),
        .item_ch          (in_ch_reg),
        .invert           (invert_reg),
        .show_numbers     (show_reg),
        .matched          (matched),
        .ctl              (ctl),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_selected       (m_selected),
        .m_matched        (m_matched),
        .m_line_number    (m_line_number),
        .m_selected_total (m_selected_total),
        .m_line_end       (m_line_end)
    );

endmodule

[src/lpf_checker.sv]
// Port-level checker for line_pattern_filter_unit, bound to the top level.
// Depends on lpf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lpf_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic                              m_selected,
    input logic [lpf_pkg::COUNT_W-1:0]       m_line_number,
    input logic [lpf_pkg::COUNT_W-1:0]       m_selected_total,
    input logic [1:0]                        m_line_end
);
    import lpf_pkg::*;

    // Stalled result beat holds
    `ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_line_number) && $stable(m_selected_total) && $stable(m_line_end))

    // An empty result register never blocks input
    `ASSERT_IMPLIES(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready)

    // A selected line is counted in its own total
    `ASSERT_IMPLIES(a_sel_counted, aclk, aresetn, m_valid && m_selected, m_selected_total != '0)

    // Selected lines never outnumber lines
    `ASSERT_IMPLIES(a_total_bound, aclk, aresetn, m_valid && m_line_number != '0, m_selected_total <= m_line_number)

    // Nothing follows the end-of-input line
    `ASSERT_NEXT(a_last_line, aclk, aresetn, m_valid && m_ready && m_line_end == END_INPUT, !m_valid)

endmodule

bind line_pattern_filter_unit lpf_checker u_lpf_checker (.*);

[tb/tb_line_pattern_filter_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for line_pattern_filter_unit: a directed table, then random text
// phases, most under random stalls, checked beat by beat against a line filter model.
// Depends on lpf_pkg and the line_pattern_filter_unit RTL.

module tb_line_pattern_filter_unit;
    import lpf_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int LINE_LIMIT   = MAX_LINE_DEF - 1;
    localparam int TEXT_ITEMS   = 1500;
    localparam int PHASES       = 12;
    // the length-limit line takes a fixed share of the budget
    localparam int PHASE_ITEMS  = (TEXT_ITEMS - LINE_LIMIT) / PHASES;
    localparam int HOLD_PHASE   = 4;
    localparam int LIMIT_PHASE  = 6;
    localparam int CALM_PHASE   = PHASES - 2;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE       = 8;
    localparam int STALL_LIMIT  = 5000;
    localparam int NUM_DIR      = 28;

    typedef struct packed {
        logic               selected;
        logic               matched;
        logic [COUNT_W-1:0] line_number;
        logic [COUNT_W-1:0] selected_total;
        line_end_t          line_end;
    } line_report_t;

    typedef enum logic { ROW_CFG, ROW_BEAT } row_op_t;

    typedef struct {
        row_op_t                op;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  wdata;
        kind_t                  kind;
        logic [CH_W-1:0]        ch;
        bit                     typed;
        line_report_t           want;
    } dir_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_valid;
    logic                   s_ready;
    logic                   s_kind;
    logic [CH_W-1:0]        s_ch;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_selected;
    logic                   m_matched;
    logic [COUNT_W-1:0]     m_line_number;
    logic [COUNT_W-1:0]     m_selected_total;
    logic [1:0]             m_line_end;

    // Model state and its copy of the registers
    logic [CFG_DATA_W-1:0]      pat_word [4];
    logic [PLEN_W-1:0]          pat_len;
    logic                       inv_sel;
    logic                       num_on;
    logic [PATTERN_MAX_DEF-1:0] hit_vec;
    logic                       hit_seen;
    int unsigned                line_chars;
    logic [COUNT_W-1:0]         lines_done;
    logic [COUNT_W-1:0]         sel_done;
    logic                       stream_closed;

    line_report_t    pending_reports [$];
    logic [CH_W-1:0] text_syms [4];
    int unsigned     mismatch_count = 0;
    int unsigned     quiet_cycles   = 0;
    int unsigned     text_items     = 0;
    bit              calm           = 1'b0;
    bit              hold_off_req   = 1'b0;

    dir_row_t dir_table [NUM_DIR] = '{
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, 8'h61, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, NEWLINE_CHAR, 1'b1,
          '{1'b1, 1'b1, 32'd0, 32'd1, END_NEWLINE}},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, NEWLINE_CHAR, 1'b1,
          '{1'b1, 1'b1, 32'd0, 32'd2, END_NEWLINE}},
        '{ROW_CFG, CFG_SHOW_NUMBERS, 64'd1, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_CFG, CFG_INVERT, 64'd1, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, NEWLINE_CHAR, 1'b1,
          '{1'b0, 1'b1, 32'd3, 32'd2, END_NEWLINE}},
        // pattern: zero byte, all-ones byte, newline
        '{ROW_CFG, CFG_PATTERN_0, 64'h0000_0000_000A_FF00, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_CFG, CFG_PATTERN_LEN, 64'd3, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_CFG, CFG_INVERT, 64'd0, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, 8'hFF, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, NEWLINE_CHAR, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, 8'hFF, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, NEWLINE_CHAR, 1'b0, '0},
        // shorten the pattern mid-line; the partial match must survive
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_CFG, CFG_PATTERN_LEN, 64'd2, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, 8'hFF, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, NEWLINE_CHAR, 1'b0, '0},
        '{ROW_CFG, CFG_INVERT, 64'd1, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_CFG, CFG_SHOW_NUMBERS, 64'd0, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, 8'h78, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, NEWLINE_CHAR, 1'b0, '0},
        '{ROW_CFG, CFG_PATTERN_0, '1, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_CFG, CFG_PATTERN_LEN, 64'd0, KIND_CHAR, 8'h00, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, 8'hFF, 1'b0, '0},
        '{ROW_BEAT, CFG_PATTERN_0, '0, KIND_CHAR, NEWLINE_CHAR, 1'b0, '0}
    };

    line_pattern_filter_unit uut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_kind           (s_kind),
        .s_ch             (s_ch),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_selected       (m_selected),
        .m_matched        (m_matched),
        .m_line_number    (m_line_number),
        .m_selected_total (m_selected_total),
        .m_line_end       (m_line_end)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic int unsigned eff_len();
        return (pat_len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(pat_len);
    endfunction

    function automatic logic [CH_W-1:0] pattern_byte(input int unsigned i);
        return pat_word[i / 8][(i % 8) * 8 +: 8];
    endfunction

    function automatic line_report_t close_line(input line_end_t how);
        line_report_t r;
        logic         hit;
        hit = hit_seen || eff_len() == 0;
        if (lines_done != COUNT_MAX) lines_done++;
        if ((hit ^ inv_sel) && sel_done != COUNT_MAX) sel_done++;
        r.selected       = hit ^ inv_sel;
        r.matched        = hit;
        r.line_number    = num_on ? lines_done : '0;
        r.selected_total = sel_done;
        r.line_end       = how;
        hit_vec    = '0;
        hit_seen   = 1'b0;
        line_chars = 0;
        return r;
    endfunction

    // Advance the filter by one beat; returns 1 when a line closes.
    function automatic bit filter_beat(input kind_t kind, input logic [CH_W-1:0] c,
                                       output line_report_t r);
        int unsigned                n;
        logic [PATTERN_MAX_DEF-1:0] hits;
        n = eff_len();
        r = '0;
        if (stream_closed) return 1'b0;
        if (kind == KIND_END) begin
            stream_closed = 1'b1;
            if (line_chars == 0) return 1'b0;
            r = close_line(END_INPUT);
            return 1'b1;
        end
        if (n != 0) begin
            hits = '0;
            for (int i = 0; i < n; i++) hits[i] = (pattern_byte(i) == c);
            hit_vec = ((hit_vec << 1) | 1) & hits;
            if (hit_vec[n-1]) hit_seen = 1'b1;
        end
        if (c == NEWLINE_CHAR) begin
            r = close_line(END_NEWLINE);
            return 1'b1;
        end
        line_chars++;
        if (line_chars >= LINE_LIMIT) begin
            r = close_line(END_LIMIT);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic logic [CH_W-1:0] text_byte();
        unique case ($urandom_range(0, 9))
            0: return CH_W'($urandom_range(0, 255));
            1, 2: begin
                if (eff_len() != 0) return pattern_byte($urandom_range(0, eff_len() - 1));
                else return text_syms[0];
            end
            default: return text_syms[$urandom_range(0, 3)];
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        unique case (index)
            CFG_PATTERN_LEN:  pat_len = value[PLEN_W-1:0];
            CFG_INVERT:       inv_sel = value[0];
            CFG_SHOW_NUMBERS: num_on  = value[0];
            default: if (index < CFG_PATTERN_LEN) pat_word[index] = value;
        endcase
    endtask

    // Hold the input until every line has come out and the pipe is empty.
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic send_beat(input kind_t kind, input logic [CH_W-1:0] c, input bit typed,
                             input line_report_t want);
        line_report_t r;
        if (!calm && $urandom_range(0, 9) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_ch    <= c;
        do @(posedge aclk); while (!s_ready);
        if (filter_beat(kind, c, r)) pending_reports.push_back(typed ? want : r);
    endtask

    task automatic send_line(input int unsigned len, input bit terminate, input bit no_break);
        logic [CH_W-1:0] c;
        int unsigned     n;
        int unsigned     at;
        n  = eff_len();
        at = (n != 0 && len >= n && $urandom_range(0, 2) == 0) ?
             $urandom_range(0, len - n) : len;
        for (int unsigned i = 0; i < len; i++) begin
            c = (i >= at && i < at + n) ? pattern_byte(i - at) : text_byte();
            while (no_break && c == NEWLINE_CHAR) c = text_byte();
            send_beat(KIND_CHAR, c, 1'b0, '0);
        end
        if (terminate) send_beat(KIND_CHAR, NEWLINE_CHAR, 1'b0, '0);
        text_items += len + terminate;
    endtask

    // Pick a pattern out of a small alphabet so that lines really match.
    task automatic setup_phase(input int p);
        logic [CFG_DATA_W-1:0] words [4];
        logic [PLEN_W-1:0]     len_cfg;
        int unsigned           plen;
        for (int k = 0; k < 4; k++) text_syms[k] = CH_W'($urandom_range(0, 255));
        unique case (p)
            0:       len_cfg = '0;
            1:       len_cfg = PLEN_W'(1);
            2:       len_cfg = PLEN_W'(PATTERN_MAX_DEF);
            3:       len_cfg = '1;
            4:       len_cfg = PLEN_W'(PATTERN_MAX_DEF + 1);
            5:       len_cfg = PLEN_W'(6);
            default: len_cfg = PLEN_W'($urandom_range(2, 12));
        endcase
        if (p == 3) text_syms[0] = 8'hFF;
        if (p == 5) text_syms[0] = 8'h00;
        plen = (len_cfg > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : len_cfg;
        for (int i = 0; i < 32; i++)
            words[i / 8][(i % 8) * 8 +: 8] = (i < plen) ?
                text_syms[$urandom_range(0, (plen > 8) ? 1 : 3)] : CH_W'($urandom_range(0, 255));
        if (p == 1) words[0][7:0] = NEWLINE_CHAR;
        if (p == 3) foreach (words[k]) words[k] = '1;
        if (p == 5) foreach (words[k]) words[k] = '0;
        for (int k = 0; k < 4; k++) write_reg(CFG_PATTERN_0 + CFG_INDEX_W'(k), words[k]);
        write_reg(CFG_PATTERN_LEN, {$urandom(), 26'($urandom()), len_cfg});
        write_reg(CFG_INVERT, {$urandom(), 31'($urandom()), 1'(p)});
        write_reg(CFG_SHOW_NUMBERS, {$urandom(), 31'($urandom()), 1'(p >> 1)});
    endtask

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 11) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin : result_check
        line_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_reports.size() == 0) begin
                $error("result beat with no line pending");
                mismatch_count++;
            end else begin
                want = pending_reports.pop_front();
                if (m_selected !== want.selected) begin
                    $error("selected: expected %0d, got %0d", want.selected, m_selected);
                    mismatch_count++;
                end
                if (m_matched !== want.matched) begin
                    $error("matched: expected %0d, got %0d", want.matched, m_matched);
                    mismatch_count++;
                end
                if (m_line_number !== want.line_number) begin
                    $error("line_number: expected %0d, got %0d", want.line_number,
                           m_line_number);
                    mismatch_count++;
                end
                if (m_selected_total !== want.selected_total) begin
                    $error("selected_total: expected %0d, got %0d", want.selected_total,
                           m_selected_total);
                    mismatch_count++;
                end
                if (m_line_end !== want.line_end) begin
                    $error("line_end: expected %0d, got %0d", want.line_end, m_line_end);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL line_pattern_filter_unit");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int unsigned phase_end;
        int unsigned len;
        aresetn   <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        s_valid   <= 1'b0;
        s_kind    <= KIND_CHAR;
        s_ch      <= '0;
        foreach (pat_word[k]) pat_word[k] = '0;
        pat_len       = '0;
        inv_sel       = 1'b0;
        num_on        = 1'b0;
        hit_vec       = '0;
        hit_seen      = 1'b0;
        line_chars    = 0;
        lines_done    = '0;
        sel_done      = '0;
        stream_closed = 1'b0;
        foreach (text_syms[k]) text_syms[k] = CH_W'(8'h61 + k);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i]) begin
            if (dir_table[i].op == ROW_CFG) begin
                drain_results();
                write_reg(dir_table[i].index, dir_table[i].wdata);
            end else begin
                send_beat(dir_table[i].kind, dir_table[i].ch, dir_table[i].typed,
                          dir_table[i].want);
            end
        end

        for (int p = 0; p < PHASES; p++) begin
            drain_results();
            calm = (p >= CALM_PHASE);
            setup_phase(p);
            if (p == HOLD_PHASE) hold_off_req = 1'b1;
            if (p == LIMIT_PHASE) begin
                // close the open line, then one line cut at the length limit
                send_line(0, 1'b1, 1'b1);
                send_line(LINE_LIMIT, 1'b0, 1'b1);
            end
            phase_end = text_items + PHASE_ITEMS;
            while (text_items < phase_end) begin
                if (p == HOLD_PHASE) len = $urandom_range(0, 2);
                else if ($urandom_range(0, 9) == 0) len = $urandom_range(25, 80);
                else len = $urandom_range(0, 24);
                send_line(len, $urandom_range(0, 7) != 0, 1'b0);
            end
            // leave a line open so the next settings land mid-line
            if (p % 2 == 1) send_line($urandom_range(1, 6), 1'b0, 1'b0);
        end

        // close the stream with characters pending, then offer beats that must be dropped
        send_line($urandom_range(1, 8), 1'b0, 1'b1);
        send_beat(KIND_END, CH_W'($urandom_range(0, 255)), 1'b0, '0);
        repeat (20) send_beat(kind_t'($urandom_range(0, 1)), CH_W'($urandom_range(0, 255)),
                              1'b0, '0);
        drain_results();

        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("PASS line_pattern_filter_unit");
        end else begin
            $display("FAIL line_pattern_filter_unit");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/lpf_pkg.sv
src/lpf_match.sv
src/lpf_line.sv
src/line_pattern_filter_unit.sv
src/lpf_checker.sv
tb/tb_line_pattern_filter_unit.sv
